@@ src/pd_pkg.sv @@
package pd_pkg;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	localparam logic PLUS_AS_SPACE_RST = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HI   = 2'd1,
		PH_LO   = 2'd2
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t       h;
		logic [7:0] d;
		h = '{ok: 1'b0, val: 4'd0};
		d = 8'd0;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
			h = '{ok: 1'b1, val: d[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + HEX_TEN;
			h = '{ok: 1'b1, val: d[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + HEX_TEN;
			h = '{ok: 1'b1, val: d[3:0]};
		end
		return h;
	endfunction

endpackage

@@ src/pd_if.sv @@
interface pd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       string_end;

	modport source (output valid, output out_byte, output byte_present, output string_end,
		input ready);
	modport sink   (input valid, input out_byte, input byte_present, input string_end,
		output ready);
endinterface

interface pd_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/percent_decoder_core.sv @@
// Percent decoder: one encoded character per request in, zero or one decoded result out.
// The result is registered and appears in the cycle after the input request is accepted.
// Throughput: one character per cycle; the escape state updates in the accept cycle,
// and input is accepted whenever the result register is empty or being drained.
// Reset (arst_n low, async): escape state cleared, result register empty, plus_as_space = 1.
module percent_decoder_core
	import pd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	pd_in_if.sink    in_ch,
	pd_out_if.source out_ch,
	pd_cfg_if.sink   cfg
);

	phase_t     phase_q, phase_d;
	logic [3:0] nib_q, nib_d;
	logic       bad_q, bad_d;
	logic       plus_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       present_q;
	logic       end_q;

	logic       accept;
	logic       have;
	logic [7:0] dec_byte;
	hex_t       hx;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	assign hx = hex_decode(in_ch.in_byte);

	always_comb begin
		phase_d  = phase_q;
		nib_d    = nib_q;
		bad_d    = bad_q;
		have     = 1'b0;
		dec_byte = 8'd0;
		case (phase_q)
			PH_HI: begin
				nib_d   = hx.ok ? hx.val : 4'd0;
				bad_d   = !hx.ok;
				phase_d = PH_LO;
			end
			PH_LO: begin
				if (!bad_q && hx.ok) begin
					have     = 1'b1;
					dec_byte = {nib_q, hx.val};
				end
				phase_d = PH_IDLE;
				nib_d   = 4'd0;
				bad_d   = 1'b0;
			end
			default: begin
				phase_d = PH_IDLE;
				if (plus_q && in_ch.in_byte == CH_PLUS) begin
					have     = 1'b1;
					dec_byte = CH_SPACE;
				end else if (in_ch.in_byte == CH_PERCENT) begin
					phase_d = PH_HI;
					nib_d   = 4'd0;
					bad_d   = 1'b0;
				end else begin
					have     = 1'b1;
					dec_byte = in_ch.in_byte;
				end
			end
		endcase
		if (in_ch.in_last) begin
			phase_d = PH_IDLE;
			nib_d   = 4'd0;
			bad_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			nib_q   <= 4'd0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
			bad_q   <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q <= PLUS_AS_SPACE_RST;
		end else if (cfg.valid && cfg.ready) begin
			plus_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= accept && (have || in_ch.in_last);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= dec_byte;
			present_q  <= have;
			end_q      <= in_ch.in_last;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.byte_present = present_q;
	assign out_ch.string_end   = end_q;

	// string end returns the escape state to idle
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.in_last |=> phase_q == PH_IDLE && nib_q == 4'd0 && !bad_q)
		else $error("escape state not cleared after last character");

	// a result without a byte only ever marks string end
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !present_q |-> end_q && out_byte_q == 8'd0)
		else $error("empty result without string end");

	// first hex digit always advances to second unless the string ended
	a_hi_to_lo: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_HI && !in_ch.in_last |=> phase_q == PH_LO)
		else $error("escape phase did not advance");

	// nibble and error flag only live while awaiting the second digit
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_LO |-> nib_q == 4'd0 && !bad_q)
		else $error("stale escape state outside second digit phase");

endmodule
